// ===== rtl/cdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdpt_pkg
// Shared constants, codes and word types for the CD audio play position
// tracker.
// ----------------------------------------------------------------------------
package cdpt_pkg;

    // Geometry
    localparam int SAMPLES_PER_SECTOR = 588;
    localparam int SECTOR_BITS        = 19;
    localparam int COUNT_W            = SECTOR_BITS + 1;
    localparam int SAMPLE_W           = $clog2(SAMPLES_PER_SECTOR + 1);
    localparam int AUDIO_W            = 16;

    localparam logic [SAMPLE_W:0]  SAMPLE_WRAP = (SAMPLE_W+1)'(SAMPLES_PER_SECTOR);
    localparam logic [COUNT_W-1:0] SECTOR_MAX  = {1'b0, {SECTOR_BITS{1'b1}}};

    // Action codes
    localparam logic [1:0] ACT_PLAY    = 2'd0;
    localparam logic [1:0] ACT_SET_END = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // End-of-range behavior
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_LOOP = 2'd1;
    localparam logic [1:0] MODE_IRQ  = 2'd2;

    typedef enum logic [1:0] {
        ST_INACTIVE = 2'd0,
        ST_PLAYING  = 2'd1,
        ST_PAUSED   = 2'd2,
        ST_STOPPED  = 2'd3
    } status_t;

    // One input word
    typedef struct packed {
        logic [1:0]                action;
        logic [SECTOR_BITS-1:0]    start_sector;
        logic                      start_paused;
        logic                      track_found;
        logic [SECTOR_BITS-1:0]    track_last_sector;
        logic [SECTOR_BITS-1:0]    end_sector_in;
        logic [1:0]                end_mode_in;
        logic signed [AUDIO_W-1:0] disc_left;
        logic signed [AUDIO_W-1:0] disc_right;
    } in_word_t;

    // One result word
    typedef struct packed {
        status_t                   status;
        logic                      sample_valid;
        logic signed [AUDIO_W-1:0] left_out;
        logic signed [AUDIO_W-1:0] right_out;
        logic [SECTOR_BITS-1:0]    position_sector;
        logic [SAMPLE_W-1:0]       position_sample;
        logic                      transfer_done_irq;
    } result_t;

endpackage

// ===== rtl/cdpt_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdpt_in_stage
// Input register: captures one word and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module cdpt_in_stage
    import cdpt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_word,
    input  logic     advance,
    output logic     word_valid,
    output in_word_t word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // Slot is free when empty or being consumed this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ===== rtl/cdpt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdpt_core
// Play state registers and the one-pass step logic: decodes the action,
// updates position and status, and forms the result word.
// ----------------------------------------------------------------------------
module cdpt_core
    import cdpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               fire,
    input  in_word_t           word,
    output result_t            result
);

    logic [COUNT_W-1:0]     disc_count_reg;
    status_t                status_reg,     status_next;
    logic [SECTOR_BITS-1:0] loop_start_reg, loop_start_next;
    logic [SECTOR_BITS-1:0] stop_sector_reg, stop_sector_next;
    logic [1:0]             end_mode_reg,   end_mode_next;
    logic [SECTOR_BITS-1:0] cur_sector_reg, cur_sector_next;
    logic [SAMPLE_W-1:0]    cur_sample_reg, cur_sample_next;

    logic [COUNT_W-1:0]     count_m1;
    logic [SECTOR_BITS-1:0] last_sector;
    logic [SAMPLE_W:0]      sample_inc;
    logic [COUNT_W-1:0]     sector_inc;
    logic [COUNT_W-1:0]     sector_step;
    logic                   sample_valid;
    logic                   irq;

    // Disc's last sector; an empty disc counts as one sector
    assign count_m1    = (disc_count_reg == '0) ? '0 : disc_count_reg - COUNT_W'(1);
    assign last_sector = (count_m1 > SECTOR_MAX) ? SECTOR_MAX[SECTOR_BITS-1:0]
                                                 : count_m1[SECTOR_BITS-1:0];

    assign sample_inc = {1'b0, cur_sample_reg} + (SAMPLE_W+1)'(1);
    assign sector_inc = {1'b0, cur_sector_reg} + COUNT_W'(1);

    // Step logic
    always_comb begin
        status_next      = status_reg;
        loop_start_next  = loop_start_reg;
        stop_sector_next = stop_sector_reg;
        end_mode_next    = end_mode_reg;
        cur_sector_next  = cur_sector_reg;
        cur_sample_next  = cur_sample_reg;
        sector_step      = sector_inc;
        sample_valid     = 1'b0;
        irq              = 1'b0;

        case (word.action)
            ACT_PLAY: begin
                if (word.track_found) begin
                    loop_start_next  = word.start_sector;
                    status_next      = word.start_paused ? ST_PAUSED : ST_PLAYING;
                    stop_sector_next = word.track_last_sector;
                    end_mode_next    = MODE_STOP;
                    cur_sample_next  = '0;
                    cur_sector_next  = word.start_sector;
                end
            end
            ACT_SET_END: begin
                stop_sector_next = (word.end_sector_in > last_sector) ? last_sector
                                                                      : word.end_sector_in;
                end_mode_next    = word.end_mode_in;
                status_next      = ST_PLAYING;
            end
            ACT_TICK: begin
                if (status_reg == ST_PLAYING) begin
                    sample_valid    = 1'b1;
                    cur_sample_next = sample_inc[SAMPLE_W-1:0];
                    if (sample_inc >= SAMPLE_WRAP) begin
                        cur_sample_next = '0;
                        // Past the end sector: clamp, then loop or stop
                        if (sector_inc > {1'b0, stop_sector_reg}) begin
                            if (sector_inc >= disc_count_reg ||
                                sector_inc > {1'b0, last_sector}) begin
                                sector_step = {1'b0, last_sector};
                            end
                            if (end_mode_reg == MODE_LOOP) begin
                                sector_step = {1'b0, loop_start_reg};
                            end else begin
                                status_next = ST_STOPPED;
                                irq         = (end_mode_reg == MODE_IRQ);
                            end
                        end
                        cur_sector_next = sector_step[SECTOR_BITS-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result word from the post-step state
    always_comb begin
        result.status            = status_next;
        result.sample_valid      = sample_valid;
        result.left_out          = sample_valid ? word.disc_left  : '0;
        result.right_out         = sample_valid ? word.disc_right : '0;
        result.position_sector   = cur_sector_next;
        result.position_sample   = cur_sample_next;
        result.transfer_done_irq = irq;
    end

    // Disc size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disc_count_reg <= COUNT_W'(1);
        end else if (cfg_wr_en) begin
            disc_count_reg <= cfg_wr_data;
        end
    end

    // Play state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= ST_INACTIVE;
            loop_start_reg  <= '0;
            stop_sector_reg <= '0;
            end_mode_reg    <= MODE_STOP;
            cur_sector_reg  <= '0;
            cur_sample_reg  <= '0;
        end else if (fire) begin
            status_reg      <= status_next;
            loop_start_reg  <= loop_start_next;
            stop_sector_reg <= stop_sector_next;
            end_mode_reg    <= end_mode_next;
            cur_sector_reg  <= cur_sector_next;
            cur_sample_reg  <= cur_sample_next;
        end
    end

endmodule

// ===== rtl/cdpt_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdpt_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module cdpt_out_stage
    import cdpt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_result,
    output logic    advance,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    result_t result_reg;

    // Load when empty or when the held word leaves this cycle
    assign advance = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            result_reg <= in_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== rtl/cd_audio_play_position_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cd_audio_play_position_tracker
// CD audio playback position tracker: play, set-end and sample-tick words in,
// one status/sample/position word out per input word.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns exactly one result word for each, in
// order. A word passes through the input register and then the result
// register, with the whole step (action decode, sample and sector advance,
// end-of-range clamp and loop/stop) done in the single pass between them.
// The input register also absorbs one word while a finished result waits on
// m_ready, so throughput stays at one word per cycle as long as the sink keeps
// up. cfg_wr_data sets the disc size in sectors (reset value 1) and should
// only be written while no word is in flight.
// ----------------------------------------------------------------------------
module cd_audio_play_position_tracker
    import cdpt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [COUNT_W-1:0]        cfg_wr_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_action,
    input  logic [SECTOR_BITS-1:0]    s_start_sector,
    input  logic                      s_start_paused,
    input  logic                      s_track_found,
    input  logic [SECTOR_BITS-1:0]    s_track_last_sector,
    input  logic [SECTOR_BITS-1:0]    s_end_sector_in,
    input  logic [1:0]                s_end_mode_in,
    input  logic signed [AUDIO_W-1:0] s_disc_left,
    input  logic signed [AUDIO_W-1:0] s_disc_right,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic                      m_sample_valid,
    output logic signed [AUDIO_W-1:0] m_left_out,
    output logic signed [AUDIO_W-1:0] m_right_out,
    output logic [SECTOR_BITS-1:0]    m_position_sector,
    output logic [SAMPLE_W-1:0]       m_position_sample,
    output logic                      m_transfer_done_irq
);

    in_word_t s_word;
    in_word_t word;
    logic     word_valid;
    logic     advance;
    result_t  result;
    result_t  m_result;

    // Pack input ports
    always_comb begin
        s_word.action            = s_action;
        s_word.start_sector      = s_start_sector;
        s_word.start_paused      = s_start_paused;
        s_word.track_found       = s_track_found;
        s_word.track_last_sector = s_track_last_sector;
        s_word.end_sector_in     = s_end_sector_in;
        s_word.end_mode_in       = s_end_mode_in;
        s_word.disc_left         = s_disc_left;
        s_word.disc_right        = s_disc_right;
    end

    cdpt_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    cdpt_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (word_valid && advance),
        .word        (word),
        .result      (result)
    );

    cdpt_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (word_valid),
        .in_result (result),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // Unpack result word
    assign m_status            = m_result.status;
    assign m_sample_valid      = m_result.sample_valid;
    assign m_left_out          = m_result.left_out;
    assign m_right_out         = m_result.right_out;
    assign m_position_sector   = m_result.position_sector;
    assign m_position_sample   = m_result.position_sample;
    assign m_transfer_done_irq = m_result.transfer_done_irq;

endmodule

// ===== bench/cd_audio_play_position_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cd_audio_play_position_tracker_test
// Self-checking bench for the CD audio play position tracker. A behavioral
// copy of the player (status, end sector, end mode, sector and sample
// position) predicts one result word per input word. Directed words cover
// the field extremes, ignored play commands, pause and the end-sector clamp.
// Randomized play sessions follow, each a play command, an optional set-end
// and a run of sample ticks long enough to cross sector boundaries, under
// several disc sizes. Random stalls on both sides, none in the last phase.
// ----------------------------------------------------------------------------
module cd_audio_play_position_tracker_test;
    import cdpt_pkg::*;

    localparam logic [SECTOR_BITS-1:0] SECTOR_TOP = '1;
    localparam int DISC_TOP   = 1 << SECTOR_BITS;
    localparam int TICK_LIMIT = 620;
    localparam int PHASE_CAP  = 6000;

    logic                      aclk;
    logic                      aresetn             = 1'b0;
    logic                      cfg_wr_en           = 1'b0;
    logic [COUNT_W-1:0]        cfg_wr_data         = '0;
    logic                      s_valid             = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_action            = ACT_PLAY;
    logic [SECTOR_BITS-1:0]    s_start_sector      = '0;
    logic                      s_start_paused      = 1'b0;
    logic                      s_track_found       = 1'b0;
    logic [SECTOR_BITS-1:0]    s_track_last_sector = '0;
    logic [SECTOR_BITS-1:0]    s_end_sector_in     = '0;
    logic [1:0]                s_end_mode_in       = MODE_STOP;
    logic signed [AUDIO_W-1:0] s_disc_left         = '0;
    logic signed [AUDIO_W-1:0] s_disc_right        = '0;
    logic                      m_valid;
    logic                      m_ready             = 1'b1;
    logic [1:0]                m_status;
    logic                      m_sample_valid;
    logic signed [AUDIO_W-1:0] m_left_out;
    logic signed [AUDIO_W-1:0] m_right_out;
    logic [SECTOR_BITS-1:0]    m_position_sector;
    logic [SAMPLE_W-1:0]       m_position_sample;
    logic                      m_transfer_done_irq;

    // Player model state
    status_t                   trk_status;
    logic [SECTOR_BITS-1:0]    loop_from;
    logic [SECTOR_BITS-1:0]    end_sec;
    logic [1:0]                end_beh;
    logic [SECTOR_BITS-1:0]    pos_sec;
    logic [SAMPLE_W-1:0]       pos_smp;
    logic [COUNT_W-1:0]        disc_count;

    result_t                   player_reports[$];
    int unsigned               words_sent;
    int unsigned               sector_steps;
    int unsigned               mismatch_count;
    int unsigned               stall_left;
    bit                        idle_on;

    cd_audio_play_position_tracker i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_start_sector      (s_start_sector),
        .s_start_paused      (s_start_paused),
        .s_track_found       (s_track_found),
        .s_track_last_sector (s_track_last_sector),
        .s_end_sector_in     (s_end_sector_in),
        .s_end_mode_in       (s_end_mode_in),
        .s_disc_left         (s_disc_left),
        .s_disc_right        (s_disc_right),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_sample_valid      (m_sample_valid),
        .m_left_out          (m_left_out),
        .m_right_out         (m_right_out),
        .m_position_sector   (m_position_sector),
        .m_position_sample   (m_position_sample),
        .m_transfer_done_irq (m_transfer_done_irq)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("cd_audio_play_position_tracker: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Player model
    // ------------------------------------------------------------------------
    task automatic reset_player();
        trk_status   = ST_INACTIVE;
        loop_from    = '0;
        end_sec      = '0;
        end_beh      = MODE_STOP;
        pos_sec      = '0;
        pos_smp      = '0;
        disc_count   = COUNT_W'(1);
        sector_steps = 0;
    endtask

    // Highest usable sector; a zero-size disc counts as one sector
    function automatic logic [COUNT_W-1:0] disc_last_sector();
        logic [COUNT_W-1:0] n;
        n = (disc_count == '0) ? COUNT_W'(1) : disc_count;
        n = n - 1'b1;
        if (n > SECTOR_MAX)
            n = SECTOR_MAX;
        return n;
    endfunction

    task automatic step_player(input in_word_t w, output result_t r);
        logic [COUNT_W-1:0] last_sec;
        logic [COUNT_W-1:0] next_sec;
        r        = '0;
        last_sec = disc_last_sector();
        case (w.action)
            ACT_PLAY: begin
                // no track: command dropped
                if (w.track_found) begin
                    loop_from  = w.start_sector;
                    trk_status = w.start_paused ? ST_PAUSED : ST_PLAYING;
                    end_sec    = w.track_last_sector;
                    end_beh    = MODE_STOP;
                    pos_smp    = '0;
                    pos_sec    = w.start_sector;
                end
            end
            ACT_SET_END: begin
                end_sec    = (w.end_sector_in > last_sec) ? last_sec[SECTOR_BITS-1:0]
                                                          : w.end_sector_in;
                end_beh    = w.end_mode_in;
                trk_status = ST_PLAYING;
            end
            ACT_TICK: begin
                if (trk_status == ST_PLAYING) begin
                    r.sample_valid = 1'b1;
                    r.left_out     = w.disc_left;
                    r.right_out    = w.disc_right;
                    if (pos_smp + 1 >= SAMPLES_PER_SECTOR) begin
                        // sector boundary
                        pos_smp      = '0;
                        sector_steps = sector_steps + 1;
                        next_sec     = {1'b0, pos_sec} + 1'b1;
                        if (next_sec > end_sec) begin
                            if (next_sec >= disc_count || next_sec > last_sec)
                                next_sec = last_sec;
                            if (end_beh == MODE_LOOP) begin
                                next_sec = {1'b0, loop_from};
                            end else begin
                                trk_status          = ST_STOPPED;
                                r.transfer_done_irq = (end_beh == MODE_IRQ);
                            end
                        end
                        pos_sec = next_sec[SECTOR_BITS-1:0];
                    end else begin
                        pos_smp = pos_smp + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.status          = trk_status;
        r.position_sector = pos_sec;
        r.position_sample = pos_smp;
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Every field random, codes within their legal range
    function automatic in_word_t random_word();
        in_word_t w;
        w.action            = 2'($urandom_range(ACT_PLAY, ACT_TICK));
        w.start_sector      = SECTOR_BITS'($urandom_range(0, SECTOR_TOP));
        w.start_paused      = 1'($urandom_range(0, 1));
        w.track_found       = 1'($urandom_range(0, 1));
        w.track_last_sector = SECTOR_BITS'($urandom_range(0, SECTOR_TOP));
        w.end_sector_in     = SECTOR_BITS'($urandom_range(0, SECTOR_TOP));
        w.end_mode_in       = 2'($urandom_range(MODE_STOP, MODE_IRQ));
        w.disc_left         = AUDIO_W'($urandom_range(0, 16'hFFFF));
        w.disc_right        = AUDIO_W'($urandom_range(0, 16'hFFFF));
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        result_t r;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_action            <= w.action;
        s_start_sector      <= w.start_sector;
        s_start_paused      <= w.start_paused;
        s_track_found       <= w.track_found;
        s_track_last_sector <= w.track_last_sector;
        s_end_sector_in     <= w.end_sector_in;
        s_end_mode_in       <= w.end_mode_in;
        s_disc_left         <= w.disc_left;
        s_disc_right        <= w.disc_right;
        do @(posedge aclk); while (!s_ready);
        step_player(w, r);
        player_reports = {player_reports, r};
        words_sent = words_sent + 1;
    endtask

    task automatic send_play(input logic [SECTOR_BITS-1:0] first, input logic paused,
                             input logic found, input logic [SECTOR_BITS-1:0] last);
        in_word_t w;
        w                   = random_word();
        w.action            = ACT_PLAY;
        w.start_sector      = first;
        w.start_paused      = paused;
        w.track_found       = found;
        w.track_last_sector = last;
        send_word(w);
    endtask

    task automatic send_set_end(input logic [SECTOR_BITS-1:0] stop_at, input logic [1:0] mode);
        in_word_t w;
        w               = random_word();
        w.action        = ACT_SET_END;
        w.end_sector_in = stop_at;
        w.end_mode_in   = mode;
        send_word(w);
    endtask

    task automatic send_tick(input logic signed [AUDIO_W-1:0] left,
                             input logic signed [AUDIO_W-1:0] right);
        in_word_t w;
        w            = random_word();
        w.action     = ACT_TICK;
        w.disc_left  = left;
        w.disc_right = right;
        send_word(w);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic finish_words();
        s_valid <= 1'b0;
        while (player_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Only called with nothing in flight
    task automatic set_disc_size(input logic [COUNT_W-1:0] sectors);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sectors;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        disc_count  = sectors;
    endtask

    // Result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count = mismatch_count + 1;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (player_reports.size() == 0) begin
                report_mismatch("result word with no input word owed");
            end else begin
                want = player_reports.pop_front();
                check_field("status", 32'(m_status), 32'(want.status));
                check_field("sample_valid", 32'(m_sample_valid), 32'(want.sample_valid));
                check_field("left_out", 32'(m_left_out), 32'(want.left_out));
                check_field("right_out", 32'(m_right_out), 32'(want.right_out));
                check_field("position_sector", 32'(m_position_sector),
                            32'(want.position_sector));
                check_field("position_sample", 32'(m_position_sample),
                            32'(want.position_sample));
                check_field("transfer_done_irq", 32'(m_transfer_done_irq),
                            32'(want.transfer_done_irq));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Disc size still at its reset value of one sector
    task automatic test_reset_defaults();
        send_tick(16'sh7FFF, 16'sh8000);
        send_play(SECTOR_TOP, 1'b1, 1'b0, SECTOR_TOP);
        send_set_end(SECTOR_TOP, MODE_IRQ);
        send_tick(16'sh8000, 16'sh7FFF);
    endtask

    task automatic test_play_commands();
        finish_words();
        set_disc_size(COUNT_W'(DISC_TOP));
        send_play(SECTOR_TOP, 1'b1, 1'b1, SECTOR_TOP);
        send_tick(16'sh1234, 16'sh4321);
        send_play('0, 1'b0, 1'b1, '0);
        send_play(SECTOR_BITS'(1234), 1'b1, 1'b0, SECTOR_BITS'(5));
        send_tick(16'sh0001, 16'shFFFE);
    endtask

    task automatic test_set_end();
        send_set_end(SECTOR_TOP, MODE_LOOP);
        send_set_end('0, MODE_IRQ);
        send_set_end(SECTOR_BITS'(300000), MODE_STOP);
        send_tick(16'sh5555, 16'shAAAA);
    endtask

    task automatic test_sample_extremes();
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh0000, 16'sh0000);
        send_tick(16'shFFFF, 16'shFFFF);
        send_tick(16'sh8000, 16'sh8000);
        send_tick(16'sh7FFF, 16'sh7FFF);
    endtask

    // One play session: play, optional set-end, ticks until it stops or hits the tick limit
    task automatic run_session(input bit idling);
        logic [COUNT_W-1:0]     last_sec;
        logic [SECTOR_BITS-1:0] first;
        logic [SECTOR_BITS-1:0] track_end;
        logic [SECTOR_BITS-1:0] stop_at;
        int unsigned            ticks;
        idle_on  = idling && ($urandom_range(0, 3) != 0);
        last_sec = disc_last_sector();
        case ($urandom_range(0, 5))
            0:       first = SECTOR_BITS'($urandom_range(0, SECTOR_TOP));
            1:       first = last_sec[SECTOR_BITS-1:0];
            default: first = SECTOR_BITS'($urandom_range(0, last_sec));
        endcase
        case ($urandom_range(0, 5))
            0:       track_end = first;
            1:       track_end = first + 1'b1;
            2:       track_end = first - 1'b1;
            3:       track_end = SECTOR_BITS'($urandom_range(0, SECTOR_TOP));
            4:       track_end = SECTOR_BITS'(last_sec + $urandom_range(0, 2));
            default: track_end = first + 2'd2;
        endcase
        send_play(first, $urandom_range(0, 4) == 0, $urandom_range(0, 9) != 0, track_end);

        if (trk_status == ST_PAUSED || $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(0, 4))
                send_tick(AUDIO_W'($urandom_range(0, 16'hFFFF)),
                          AUDIO_W'($urandom_range(0, 16'hFFFF)));
            case ($urandom_range(0, 4))
                0:       stop_at = first;
                1:       stop_at = first + 1'b1;
                2:       stop_at = SECTOR_BITS'($urandom_range(0, SECTOR_TOP));
                3:       stop_at = last_sec[SECTOR_BITS-1:0];
                default: stop_at = '0;
            endcase
            send_set_end(stop_at, 2'($urandom_range(MODE_STOP, MODE_IRQ)));
        end

        // Ticks, with the odd stray command mixed in
        ticks = 0;
        while (trk_status == ST_PLAYING && ticks < TICK_LIMIT) begin
            if ($urandom_range(0, 199) == 0)
                send_word(random_word());
            else
                send_tick(AUDIO_W'($urandom_range(0, 16'hFFFF)),
                          AUDIO_W'($urandom_range(0, 16'hFFFF)));
            ticks = ticks + 1;
        end
        repeat ($urandom_range(1, 3))
            send_tick(AUDIO_W'($urandom_range(0, 16'hFFFF)),
                      AUDIO_W'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic test_playback(input logic [COUNT_W-1:0] sectors,
                                 input int unsigned word_goal,
                                 input int unsigned step_goal, input bit idling);
        int unsigned words_at;
        int unsigned steps_at;
        finish_words();
        set_disc_size(sectors);
        words_at = words_sent;
        steps_at = sector_steps;
        while ((words_sent - words_at < word_goal || sector_steps - steps_at < step_goal)
               && words_sent - words_at < PHASE_CAP)
            run_session(idling);
    endtask

    initial begin
        words_sent     = 0;
        mismatch_count = 0;
        stall_left     = 0;
        idle_on        = 1'b1;
        reset_player();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_play_commands();
        test_set_end();
        test_sample_extremes();
        test_playback(COUNT_W'(DISC_TOP), 300, 1, 1'b1);
        test_playback(COUNT_W'(1), 300, 1, 1'b1);
        test_playback(COUNT_W'($urandom_range(2, 16)), 300, 1, 1'b0);

        finish_words();
        if (mismatch_count == 0)
            $display("cd_audio_play_position_tracker: match");
        else
            $display("cd_audio_play_position_tracker: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cdpt_pkg.sv
rtl/cdpt_in_stage.sv
rtl/cdpt_core.sv
rtl/cdpt_out_stage.sv
rtl/cd_audio_play_position_tracker.sv
bench/cd_audio_play_position_tracker_test.sv
